// ===== src/pidc_pkg.sv =====
// pidc_pkg: shared types, constants and helpers of the position pid controller
// used by pidc_front, pidc_back and position_pid_controller_top
`default_nettype none

package pidc_pkg;

    localparam int DATA_W  = 32;
    localparam int GAIN_W  = 15;
    localparam int LIM_W   = 31;
    localparam int CFG_IDX_W = 3;

    // parameter defaults
    localparam int CHANNELS_DEF  = 2;
    localparam int OUT_LIMIT_DEF = 1000;
    localparam int QUEUE_DEPTH   = 4;

    // item kinds
    localparam logic KIND_PID = 1'b0;
    localparam logic KIND_FF  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP_CH0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_CH0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD_CH0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KP_CH1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KI_CH1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KD_CH1    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIM_PID   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIM_FF    = 3'd7;

    // unsigned 32-bit division by constants as multiply and shift, exact for all inputs
    localparam logic [31:0] M_DIV10   = 32'hCCCC_CCCD;
    localparam int          SH_DIV10  = 35;
    localparam logic [31:0] M_DIV100  = 32'h51EB_851F;
    localparam int          SH_DIV100 = 37;
    localparam logic [31:0] M_DIV250  = 32'h1062_4DD3;
    localparam int          SH_DIV250 = 36;
    localparam int          Q10_W     = 64 - SH_DIV10;
    localparam int          Q100_W    = 64 - SH_DIV100;
    localparam int          Q250_W    = 64 - SH_DIV250;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } t_gains;

    // one classified item on its way from front to back
    typedef struct packed {
        logic              kind;
        logic              ch;
        logic [DATA_W-1:0] err;
        logic [DATA_W-1:0] integ;
        logic [DATA_W-1:0] rate;
        logic [DATA_W-1:0] ff;
    } t_job;

    function automatic logic [DATA_W-1:0] abs32(input logic [DATA_W-1:0] x);
        return x[DATA_W-1] ? (~x + 32'd1) : x;
    endfunction

    function automatic logic [DATA_W-1:0] apply_sign(input logic neg,
                                                     input logic [DATA_W-1:0] mag);
        return neg ? (~mag + 32'd1) : mag;
    endfunction

endpackage

`default_nettype wire

// ===== src/pidc_queue.sv =====
// pidc_queue: small register fifo that decouples the front and back parts
// depends on nothing but its parameters
`default_nettype none

module pidc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/pidc_front.sv =====
// pidc_front: takes items, forms the error and updates per-channel state
// depends on pidc_pkg (t_job, widths)
`default_nettype none

module pidc_front #(
    parameter int CHANNELS = pidc_pkg::CHANNELS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_kind,
    input  wire logic                              i_channel,
    input  wire logic [pidc_pkg::DATA_W-1:0]       i_target,
    input  wire logic [pidc_pkg::DATA_W-1:0]       i_measured,
    input  wire logic [pidc_pkg::DATA_W-1:0]       i_ff,
    input  wire logic [pidc_pkg::LIM_W-1:0]        i_lim_pid,
    input  wire logic [pidc_pkg::LIM_W-1:0]        i_lim_ff,
    output logic                                   o_push,
    output pidc_pkg::t_job                         o_job,
    input  wire logic                              i_full
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                          r_f1_valid;
    logic                          r_f1_kind;
    logic                          r_f1_ch;
    logic [pidc_pkg::DATA_W-1:0]   r_f1_err;
    logic [pidc_pkg::DATA_W-1:0]   r_f1_ff;

    logic [pidc_pkg::DATA_W-1:0]   r_last_err [CHANNELS];
    logic [pidc_pkg::DATA_W-1:0]   r_integ    [CHANNELS];
    logic [pidc_pkg::DATA_W-1:0]   r_rate     [CHANNELS];

    logic                          n_ch;
    logic [pidc_pkg::DATA_W-1:0]   n_err;
    logic [IDX_W-1:0]              idx;
    logic [pidc_pkg::DATA_W-1:0]   s_raw, diff, six_diff, rate_sum, n_rate, n_integ;
    logic [pidc_pkg::LIM_W-1:0]    lim;
    logic signed [pidc_pkg::DATA_W:0] s_ext, lim_p, lim_n;

    assign o_ready = !r_f1_valid || !i_full;
    assign o_push  = r_f1_valid && !i_full;

    // channels past the last one fold onto the last one
    assign n_ch  = (CHANNELS > 1) ? i_channel : 1'b0;
    assign n_err = (i_kind == pidc_pkg::KIND_FF) ? (i_measured - i_target)
                                                 : (i_target - i_measured);
    assign idx   = IDX_W'(r_f1_ch);

    always_comb begin
        s_raw    = r_integ[idx] + r_f1_err;
        lim      = (r_f1_kind == pidc_pkg::KIND_FF) ? i_lim_ff : i_lim_pid;
        s_ext    = {s_raw[pidc_pkg::DATA_W-1], s_raw};
        lim_p    = {2'b00, lim};
        lim_n    = -lim_p;
        if (s_ext >= lim_p) begin
            n_integ = lim_p[pidc_pkg::DATA_W-1:0];
        end else if (s_ext <= lim_n) begin
            n_integ = lim_n[pidc_pkg::DATA_W-1:0];
        end else begin
            n_integ = s_raw;
        end
        // filtered derivative: (2*d + 6*(e - e_prev)) >>> 3
        diff     = r_f1_err - r_last_err[idx];
        six_diff = (diff << 2) + (diff << 1);
        rate_sum = (r_rate[idx] << 1) + six_diff;
        n_rate   = $signed(rate_sum) >>> 3;
    end

    always_comb begin
        o_job.kind  = r_f1_kind;
        o_job.ch    = r_f1_ch;
        o_job.err   = r_f1_err;
        o_job.integ = n_integ;
        o_job.rate  = n_rate;
        o_job.ff    = r_f1_ff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_last_err[c] <= '0;
                r_integ[c]    <= '0;
                r_rate[c]     <= '0;
            end
        end else begin
            if (o_ready) begin
                r_f1_valid <= i_valid;
            end
            if (o_push) begin
                r_last_err[idx] <= r_f1_err;
                r_integ[idx]    <= n_integ;
                if (r_f1_kind == pidc_pkg::KIND_PID) begin
                    r_rate[idx] <= n_rate;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_f1_kind <= i_kind;
            r_f1_ch   <= n_ch;
            r_f1_err  <= n_err;
            r_f1_ff   <= i_ff;
        end
    end

endmodule

`default_nettype wire

// ===== src/pidc_back.sv =====
// pidc_back: four-stage multiply pipeline that forms the drive from a queued job
// depends on pidc_pkg (t_job, t_gains, reciprocal constants, helpers)
`default_nettype none

module pidc_back #(
    parameter int OUT_LIMIT = pidc_pkg::OUT_LIMIT_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire pidc_pkg::t_job               i_job,
    input  wire logic                         i_job_valid,
    output logic                              o_pop,
    input  wire pidc_pkg::t_gains [1:0]       i_gains,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [pidc_pkg::DATA_W-1:0]       o_drive,
    output logic [pidc_pkg::DATA_W-1:0]       o_err
);

    localparam logic signed [pidc_pkg::DATA_W:0] OUT_HI = (pidc_pkg::DATA_W + 1)'(OUT_LIMIT);
    localparam logic signed [pidc_pkg::DATA_W:0] OUT_LO = -OUT_HI;

    logic adv;
    logic r_v1, r_v2, r_v3, r_v4;

    // stage 1: gain products and s/10 magnitude
    logic                          r1_kind, r1_ch, r1_sneg;
    logic [31:0]                   r1_p, r1_d, r1_i1, r1_err, r1_ff;
    logic [pidc_pkg::Q10_W-1:0]    r1_q10;
    pidc_pkg::t_gains              g1, g2;
    logic [63:0]                   prod10;

    // stage 2: integral product and /100 magnitudes of p and d
    logic                          r2_kind, r2_psgn, r2_dsgn;
    logic [31:0]                   r2_i, r2_err, r2_ff;
    logic [pidc_pkg::Q100_W-1:0]   r2_pq, r2_dq;
    logic [31:0]                   n_q10, n_i0;
    logic [63:0]                   prod_p, prod_d;

    // stage 3: integral divide, signs restored on p and d
    logic                          r3_kind, r3_isgn;
    logic [31:0]                   r3_p, r3_d, r3_err, r3_ff;
    logic [pidc_pkg::Q250_W-1:0]   r3_iq, n_iq;
    logic [63:0]                   prod_i;

    // stage 4: output register
    logic [31:0]                   r4_drive, r4_err;
    logic [31:0]                   i_val, sum_pid, sum_ff;
    logic signed [pidc_pkg::DATA_W:0] sum_ext;
    logic [31:0]                   n_drive;

    assign adv     = !r_v4 || i_ready;
    assign o_pop   = adv && i_job_valid;
    assign o_valid = r_v4;
    assign o_drive = r4_drive;
    assign o_err   = r4_err;

    assign g1     = i_gains[i_job.ch];
    assign g2     = i_gains[r1_ch];
    assign prod10 = {32'b0, pidc_pkg::abs32(i_job.integ)} * {32'b0, pidc_pkg::M_DIV10};

    assign n_q10  = pidc_pkg::apply_sign(r1_sneg, 32'(r1_q10));
    assign n_i0   = {17'b0, g2.ki} * n_q10;
    assign prod_p = {32'b0, pidc_pkg::abs32(r1_p)} * {32'b0, pidc_pkg::M_DIV100};
    assign prod_d = {32'b0, pidc_pkg::abs32(r1_d)} * {32'b0, pidc_pkg::M_DIV100};

    // kind 0 divides the integral term by 250, kind 1 by 100
    assign prod_i = {32'b0, pidc_pkg::abs32(r2_i)} *
                    {32'b0, (r2_kind == pidc_pkg::KIND_FF) ? pidc_pkg::M_DIV100
                                                           : pidc_pkg::M_DIV250};
    assign n_iq   = (r2_kind == pidc_pkg::KIND_FF)
                    ? pidc_pkg::Q250_W'(prod_i[63:pidc_pkg::SH_DIV100])
                    : prod_i[63:pidc_pkg::SH_DIV250];

    always_comb begin
        i_val   = pidc_pkg::apply_sign(r3_isgn, 32'(r3_iq));
        sum_pid = r3_p + i_val + r3_d;
        sum_ff  = r3_p + i_val + r3_ff;
        sum_ext = {sum_ff[31], sum_ff};
        if (r3_kind == pidc_pkg::KIND_PID) begin
            n_drive = sum_pid;
        end else if (sum_ext >= OUT_HI) begin
            n_drive = OUT_HI[31:0];
        end else if (sum_ext <= OUT_LO) begin
            n_drive = OUT_LO[31:0];
        end else begin
            n_drive = sum_ff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_job_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_kind  <= i_job.kind;
            r1_ch    <= i_job.ch;
            r1_err   <= i_job.err;
            r1_ff    <= i_job.ff;
            r1_p     <= {17'b0, g1.kp} * i_job.err;
            r1_d     <= {17'b0, g1.kd} * i_job.rate;
            r1_i1    <= {17'b0, g1.ki} * i_job.integ;
            r1_sneg  <= i_job.integ[31];
            r1_q10   <= prod10[63:pidc_pkg::SH_DIV10];

            r2_kind  <= r1_kind;
            r2_err   <= r1_err;
            r2_ff    <= r1_ff;
            r2_i     <= (r1_kind == pidc_pkg::KIND_FF) ? r1_i1 : n_i0;
            r2_psgn  <= r1_p[31];
            r2_dsgn  <= r1_d[31];
            r2_pq    <= prod_p[63:pidc_pkg::SH_DIV100];
            r2_dq    <= prod_d[63:pidc_pkg::SH_DIV100];

            r3_kind  <= r2_kind;
            r3_err   <= r2_err;
            r3_ff    <= r2_ff;
            r3_p     <= pidc_pkg::apply_sign(r2_psgn, 32'(r2_pq));
            r3_d     <= pidc_pkg::apply_sign(r2_dsgn, 32'(r2_dq));
            r3_isgn  <= r2_i[31];
            r3_iq    <= n_iq;

            r4_drive <= n_drive;
            r4_err   <= r3_err;
        end
    end

endmodule

`default_nettype wire

// ===== src/position_pid_controller_top.sv =====
// position_pid_controller_top: two-channel position controller, pid or pi with feed-forward
// depends on pidc_pkg, pidc_front, pidc_queue and pidc_back
//
// usage:
//   input stream: tdata = target_pos[31:0], measured_pos[63:32], feed_forward[95:64];
//   tuser = kind[0], channel[1]. output stream: tdata = drive[31:0],
//   position_error[63:32]. gains and integral limits are written through the
//   cfg port (we, index, data) while no transaction is in flight.
// path: a transaction accepted on the input passes the input register, the state update into
//   the queue, three multiply stages and the output register before its result is valid.
// throughput: one transaction per cycle sustained while the receiver holds tready high; the
//   per-channel state update is formed in the front, the multipliers are pipelined in the back.
// stall: when the receiver holds tready low the back pipeline freezes with its result
//   on the port; the front keeps taking transactions until the four-entry queue and
//   its input register are full, then drops tready.
// reset: synchronous active low; clears gains, limits, per-channel error, integral and
//   filter state, the queue and all valid flags.
`default_nettype none

module position_pid_controller_top #(
    parameter int CHANNELS  = pidc_pkg::CHANNELS_DEF,
    parameter int OUT_LIMIT = pidc_pkg::OUT_LIMIT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [95:0]                       i_s_axis_tdata,  // target_pos, measured_pos, feed_forward
    input  wire logic [1:0]                        i_s_axis_tuser,  // kind, channel
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic [63:0]                            o_m_axis_tdata,  // drive, position_error
    input  wire logic                              i_cfg_we,
    input  wire logic [pidc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pidc_pkg::LIM_W-1:0]        i_cfg_data
);

    pidc_pkg::t_gains [1:0]          r_gains;
    logic [pidc_pkg::LIM_W-1:0]      r_lim_pid, r_lim_ff;

    logic                            push, pop, q_full, q_empty;
    pidc_pkg::t_job                  job_in, job_out;
    logic [$bits(pidc_pkg::t_job)-1:0] q_dout;
    logic [pidc_pkg::DATA_W-1:0]     drive, err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains   <= '0;
            r_lim_pid <= '0;
            r_lim_ff  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pidc_pkg::REG_KP_CH0:  r_gains[0].kp <= i_cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_KI_CH0:  r_gains[0].ki <= i_cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_KD_CH0:  r_gains[0].kd <= i_cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_KP_CH1:  r_gains[1].kp <= i_cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_KI_CH1:  r_gains[1].ki <= i_cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_KD_CH1:  r_gains[1].kd <= i_cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::REG_LIM_PID: r_lim_pid     <= i_cfg_data;
                pidc_pkg::REG_LIM_FF:  r_lim_ff      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pidc_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_kind     (i_s_axis_tuser[0]),
        .i_channel  (i_s_axis_tuser[1]),
        .i_target   (i_s_axis_tdata[31:0]),
        .i_measured (i_s_axis_tdata[63:32]),
        .i_ff       (i_s_axis_tdata[95:64]),
        .i_lim_pid  (r_lim_pid),
        .i_lim_ff   (r_lim_ff),
        .o_push     (push),
        .o_job      (job_in),
        .i_full     (q_full)
    );

    pidc_queue #(
        .WIDTH ($bits(pidc_pkg::t_job)),
        .DEPTH (pidc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (q_dout),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign job_out = pidc_pkg::t_job'(q_dout);

    pidc_back #(
        .OUT_LIMIT (OUT_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_valid (!q_empty),
        .o_pop       (pop),
        .i_gains     (r_gains),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_drive     (drive),
        .o_err       (err)
    );

    assign o_m_axis_tdata = {err, drive};

endmodule

`default_nettype wire
